FILE: rtl/sensor_condition_matcher_defines.svh
// ----------------------------------------------------------------------------
// sensor condition matcher assertion macros
// shared assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef SENSOR_CONDITION_MATCHER_DEFINES_SVH
`define SENSOR_CONDITION_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define SCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCM_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCM_ASSERT(lbl, prop, msg)
`define SCM_ASSERT_NR(lbl, prop, msg)
`endif

`endif

FILE: rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// shared types and constants of the sensor condition matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned STATE_BITS_DEF  = 2;
  localparam int unsigned SENSOR_W        = 16;
  localparam int unsigned FIELD_STATE_W   = 2;
  localparam int unsigned COND_W          = 16;
  localparam int unsigned OPCODE_W        = 2;
  localparam int unsigned KIND_W          = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_CHANGE = 2'd1,
    OP_EMPTY  = 2'd2
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    EV_MET   = 2'd0,
    EV_UNMET = 2'd1,
    EV_FULL  = 2'd2
  } event_kind_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [SENSOR_W-1:0]      sensor_id;
    logic [FIELD_STATE_W-1:0] sensor_state;
    logic                     last_change;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [COND_W-1:0] event_condition;
  } out_beat_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic result_needed;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/scm_stream_if.sv
// ----------------------------------------------------------------------------
// scm_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl
// sequencer: captures a beat, then commits it once no event is due or the result slot is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sensor_condition_matcher_defines.svh"

module scm_ctrl
  import scm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = !sts_i.result_needed || sts_i.out_free;
        if (cmd_o.execute) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `SCM_ASSERT(a_capture_to_exec, cmd_o.capture |=> (state_q == S_EXEC), "capture lost")
  `SCM_ASSERT(a_no_cmd_overlap, !(cmd_o.capture && cmd_o.execute), "capture during execute")
  `SCM_ASSERT(a_stall_on_full, (state_q == S_EXEC && sts_i.result_needed && !sts_i.out_free)
    |=> (state_q == S_EXEC), "result slot overrun")

endmodule

FILE: rtl/scm_datapath.sv
// ----------------------------------------------------------------------------
// scm_datapath
// requirement table with parallel match, evaluation flags and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sensor_condition_matcher_defines.svh"

module scm_datapath
  import scm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned STATE_BITS  = STATE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [COND_W-1:0] cfg_wdata_i,
  input  in_beat_t          in_beat_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_beat_t         out_beat_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [COND_W-1:0]     cond_num_q;
  logic [SENSOR_W-1:0]   req_sensor_q [TABLE_DEPTH];
  logic [STATE_BITS-1:0] req_state_q  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] req_valid_q;
  logic                  cond_active_q, cond_active_d;
  logic                  eval_mismatch_q, eval_mismatch_d;

  logic [OPCODE_W-1:0]   op_q;
  logic [SENSOR_W-1:0]   sid_q;
  logic [STATE_BITS-1:0] st_q, st_d;
  logic                  last_q;
  logic [TABLE_DEPTH-1:0] hit_q, hit_d;
  logic                  mism_hit_q, mism_hit_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic                  free_any_q, free_any_d;

  logic [STATE_BITS+FIELD_STATE_W-1:0] st_ext;
  logic                  found, mism_all, result, write_new, update_hit;
  event_kind_e           kind;

  logic                  out_valid_q, out_valid_d;
  logic [KIND_W-1:0]     out_kind_q;
  logic [COND_W-1:0]     out_cond_q;

  assign st_ext = {{STATE_BITS{1'b0}}, in_beat_i.sensor_state};
  assign st_d   = st_ext[STATE_BITS-1:0];

  always_comb begin
    hit_d      = '0;
    mism_hit_d = 1'b0;
    free_any_d = 1'b0;
    free_idx_d = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_d[i] = req_valid_q[i] && (req_sensor_q[i] == in_beat_i.sensor_id);
      if (hit_d[i] && (req_state_q[i] != st_d)) begin
        mism_hit_d = 1'b1;
      end
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!req_valid_q[i]) begin
        free_any_d = 1'b1;
        free_idx_d = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_beat_i.opcode;
      sid_q      <= in_beat_i.sensor_id;
      st_q       <= st_d;
      last_q     <= in_beat_i.last_change;
      hit_q      <= hit_d;
      mism_hit_q <= mism_hit_d;
      free_idx_q <= free_idx_d;
      free_any_q <= free_any_d;
    end
  end

  assign found    = |hit_q;
  assign mism_all = eval_mismatch_q || mism_hit_q;

  always_comb begin
    result          = 1'b0;
    kind            = EV_MET;
    write_new       = 1'b0;
    update_hit      = 1'b0;
    cond_active_d   = cond_active_q;
    eval_mismatch_d = eval_mismatch_q;
    unique case (op_q)
      OP_ADD: begin
        update_hit = found;
        write_new  = !found && free_any_q;
        result     = !found && !free_any_q;
        kind       = EV_FULL;
      end
      OP_CHANGE: begin
        eval_mismatch_d = mism_all;
        if (last_q) begin
          result          = mism_all == cond_active_q;
          kind            = mism_all ? EV_UNMET : EV_MET;
          cond_active_d   = !mism_all;
          eval_mismatch_d = 1'b0;
        end
      end
      OP_EMPTY: begin
        result          = !cond_active_q;
        kind            = EV_MET;
        cond_active_d   = 1'b1;
        eval_mismatch_d = 1'b0;
      end
      default: begin
        result = 1'b0;
      end
    endcase
  end

  assign sts_o.result_needed = result;
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_num_q      <= '0;
      req_valid_q     <= '0;
      cond_active_q   <= 1'b0;
      eval_mismatch_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cond_num_q <= cfg_wdata_i;
      end
      if (cmd_i.execute) begin
        cond_active_q   <= cond_active_d;
        eval_mismatch_q <= eval_mismatch_d;
        if (write_new) begin
          req_valid_q[free_idx_q] <= 1'b1;
        end
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if ((update_hit && hit_q[i]) || (write_new && free_idx_q == IDX_W'(i))) begin
          req_state_q[i] <= st_q;
        end
        if (write_new && free_idx_q == IDX_W'(i)) begin
          req_sensor_q[i] <= sid_q;
        end
      end
    end
    if (cmd_i.execute && result) begin
      out_kind_q <= kind;
      out_cond_q <= cond_num_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.execute && result) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_beat_o.event_kind      = out_kind_q;
  assign out_beat_o.event_condition = out_cond_q;

  `SCM_ASSERT(a_hit_unique, cmd_i.execute |-> $onehot0(hit_q), "duplicate sensor in table")
  `SCM_ASSERT(a_no_overwrite, (cmd_i.execute && result) |-> (!out_valid_q || out_ready_i),
    "pending event overwritten")
  `SCM_ASSERT(a_empty_clears, (cmd_i.execute && op_q == OP_EMPTY)
    |=> (!eval_mismatch_q && cond_active_q), "empty evaluation not met")

endmodule

FILE: rtl/sensor_condition_matcher.sv
// ----------------------------------------------------------------------------
// sensor_condition_matcher
// requirement table for one condition with met/unmet/full event reporting
// ----------------------------------------------------------------------------
// Each input beat passes through a capture step, which compares the sensor
// number against every table entry in parallel and finds the lowest free slot,
// and an execute step, which updates the table and evaluation flags. A beat
// that raises an event waits in its execute step while the event register still
// holds an untaken event; a new beat is taken only once the last is committed.
// The event register lets the next beat enter while an event waits. Events
// carry the condition number held at the time the beat is committed.
`timescale 1ns / 1ps

module sensor_condition_matcher
  import scm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned STATE_BITS  = STATE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [COND_W-1:0] cfg_wdata_i,
  scm_stream_if.sink        in_i,
  scm_stream_if.source      out_o
);

  cmd_t cmd;
  sts_t sts;

  scm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .STATE_BITS  (STATE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_beat_i   (in_i.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_beat_o  (out_o.payload)
  );

endmodule
